// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define KF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== rtl/kf2_pkg.sv =====
// ---------------------------------------------------------------------------
// kf2_pkg
// Types, constants and the micro-op table of the two-state Kalman filter.
// ---------------------------------------------------------------------------
package kf2_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int OPD_W         = 33;          // multiplier operand width
    localparam int ACC_W         = 2 * OPD_W;   // full product / accumulator
    localparam int CFG_IDX_W     = 2;
    localparam int STEP_W        = 5;
    localparam int QBITS         = 31;          // quotient bits below saturation
    localparam int QCNT_W        = 5;

    localparam logic [STEP_W-1:0] STEP_DET  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_M0   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd21;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_Q  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R2 = 2'd2;

    // operand A select
    localparam logic [3:0] A_S0  = 4'd0;
    localparam logic [3:0] A_P0  = 4'd1;
    localparam logic [3:0] A_P1  = 4'd2;
    localparam logic [3:0] A_P2  = 4'd3;
    localparam logic [3:0] A_P3  = 4'd4;
    localparam logic [3:0] A_K0  = 4'd5;
    localparam logic [3:0] A_K1  = 4'd6;
    localparam logic [3:0] A_K2  = 4'd7;
    localparam logic [3:0] A_K3  = 4'd8;
    localparam logic [3:0] A_IK0 = 4'd9;
    localparam logic [3:0] A_IK1 = 4'd10;
    localparam logic [3:0] A_IK2 = 4'd11;
    localparam logic [3:0] A_IK3 = 4'd12;

    // operand B select
    localparam logic [2:0] B_S3 = 3'd0;
    localparam logic [2:0] B_P0 = 3'd1;
    localparam logic [2:0] B_P1 = 3'd2;
    localparam logic [2:0] B_P2 = 3'd3;
    localparam logic [2:0] B_P3 = 3'd4;
    localparam logic [2:0] B_S0 = 3'd5;
    localparam logic [2:0] B_Y0 = 3'd6;
    localparam logic [2:0] B_Y1 = 3'd7;

    // accumulator base on the first product of a sum
    localparam logic [1:0] BASE_ZERO = 2'd0;
    localparam logic [1:0] BASE_X0   = 2'd1;
    localparam logic [1:0] BASE_X1   = 2'd2;

    // result destination
    localparam logic [3:0] DST_NONE = 4'd0;
    localparam logic [3:0] DST_DET  = 4'd1;
    localparam logic [3:0] DST_M    = 4'd2;
    localparam logic [3:0] DST_X0   = 4'd3;
    localparam logic [3:0] DST_X1   = 4'd4;
    localparam logic [3:0] DST_C0   = 4'd5;
    localparam logic [3:0] DST_C1   = 4'd6;
    localparam logic [3:0] DST_C2   = 4'd7;
    localparam logic [3:0] DST_C3   = 4'd8;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [2:0] b_sel;
        logic       neg_b;
        logic       first;
        logic       sub;
        logic [1:0] base;
        logic [3:0] dst;
        logic       div;
        logic [1:0] kidx;
    } op_t;

    typedef struct packed {
        logic load_in;
        logic pred;
        logic mul_en;
        logic acc_en;
        logic div_start;
        logic keep_pred;
        logic out_load;
        logic singular;
        op_t  op;
    } ctrl_t;

    typedef struct packed {
        logic det_zero;
        logic div_done;
    } stat_t;

    function automatic op_t mk_op(logic [3:0] a, logic [2:0] b, logic neg, logic first,
                                  logic sub, logic [1:0] base, logic [3:0] dst,
                                  logic div, logic [1:0] kidx);
        op_t o;
        o.a_sel = a;   o.b_sel = b;  o.neg_b = neg; o.first = first;
        o.sub   = sub; o.base = base; o.dst  = dst;  o.div = div;
        o.kidx  = kidx;
        return o;
    endfunction

    // Product sequence: det, four adjugate sums with a divide each, estimate, covariance.
    function automatic op_t step_op(logic [STEP_W-1:0] idx);
        op_t o;
        unique case (idx)
            5'd0:  o = mk_op(A_S0,  B_S3, 1'b0, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd0);
            5'd1:  o = mk_op(A_P1,  B_P2, 1'b0, 1'b0, 1'b1, BASE_ZERO, DST_DET,  1'b0, 2'd0);
            5'd2:  o = mk_op(A_P0,  B_S3, 1'b0, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd0);
            5'd3:  o = mk_op(A_P1,  B_P2, 1'b1, 1'b0, 1'b0, BASE_ZERO, DST_M,    1'b1, 2'd0);
            5'd4:  o = mk_op(A_P0,  B_P1, 1'b1, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd1);
            5'd5:  o = mk_op(A_P1,  B_S0, 1'b0, 1'b0, 1'b0, BASE_ZERO, DST_M,    1'b1, 2'd1);
            5'd6:  o = mk_op(A_P2,  B_S3, 1'b0, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd2);
            5'd7:  o = mk_op(A_P3,  B_P2, 1'b1, 1'b0, 1'b0, BASE_ZERO, DST_M,    1'b1, 2'd2);
            5'd8:  o = mk_op(A_P2,  B_P1, 1'b1, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd3);
            5'd9:  o = mk_op(A_P3,  B_S0, 1'b0, 1'b0, 1'b0, BASE_ZERO, DST_M,    1'b1, 2'd3);
            5'd10: o = mk_op(A_K0,  B_Y0, 1'b0, 1'b1, 1'b0, BASE_X0,   DST_NONE, 1'b0, 2'd0);
            5'd11: o = mk_op(A_K1,  B_Y1, 1'b0, 1'b0, 1'b0, BASE_ZERO, DST_X0,   1'b0, 2'd0);
            5'd12: o = mk_op(A_K2,  B_Y0, 1'b0, 1'b1, 1'b0, BASE_X1,   DST_NONE, 1'b0, 2'd0);
            5'd13: o = mk_op(A_K3,  B_Y1, 1'b0, 1'b0, 1'b0, BASE_ZERO, DST_X1,   1'b0, 2'd0);
            5'd14: o = mk_op(A_IK0, B_P0, 1'b0, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd0);
            5'd15: o = mk_op(A_IK1, B_P2, 1'b0, 1'b0, 1'b0, BASE_ZERO, DST_C0,   1'b0, 2'd0);
            5'd16: o = mk_op(A_IK0, B_P1, 1'b0, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd0);
            5'd17: o = mk_op(A_IK1, B_P3, 1'b0, 1'b0, 1'b0, BASE_ZERO, DST_C1,   1'b0, 2'd0);
            5'd18: o = mk_op(A_IK2, B_P0, 1'b0, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd0);
            5'd19: o = mk_op(A_IK3, B_P2, 1'b0, 1'b0, 1'b0, BASE_ZERO, DST_C2,   1'b0, 2'd0);
            5'd20: o = mk_op(A_IK2, B_P1, 1'b0, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd0);
            5'd21: o = mk_op(A_IK3, B_P3, 1'b0, 1'b0, 1'b0, BASE_ZERO, DST_C3,   1'b0, 2'd0);
            default: o = mk_op(A_S0, B_S3, 1'b0, 1'b1, 1'b0, BASE_ZERO, DST_NONE, 1'b0, 2'd0);
        endcase
        return o;
    endfunction

    // Clamp a wide signed value to 32 bits.
    function automatic logic [DATA_W-1:0] sat32(logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (!v[ACC_W-1] && (|v[ACC_W-1:DATA_W-1]))
            r = {1'b0, {(DATA_W-1){1'b1}}};
        else if (v[ACC_W-1] && !(&v[ACC_W-1:DATA_W-1]))
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/kf2_divider.sv =====
// ---------------------------------------------------------------------------
// kf2_divider
// Serial signed fixed-point divider for the gain: sat32(trunc(num*2^F/den)),
// one quotient bit per cycle after an up-front overflow check.
// ---------------------------------------------------------------------------
module kf2_divider #(
    parameter int FRAC_BITS = kf2_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [kf2_pkg::ACC_W-1:0] num,
    input  logic signed [kf2_pkg::ACC_W-1:0] den,
    output logic                             done,
    output logic        [kf2_pkg::DATA_W-1:0] quot
);
    import kf2_pkg::*;

    localparam int DVD_W = ACC_W + FRAC_BITS;
    localparam int REM_W = ACC_W + 1;

    logic [ACC_W-1:0]  mag_n, mag_d;
    logic [DVD_W-1:0]  dvd, dvd_hi;
    logic              ovf;
    logic [REM_W-1:0]  trial;
    logic              ge;

    logic              busy_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QBITS-1:0]  lo_reg, quo_reg;
    logic [ACC_W-1:0]  d_reg;
    logic              neg_reg, ovf_reg;
    logic [DATA_W-1:0] q32;

    // operand magnitudes and the scaled dividend
    assign mag_n  = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign mag_d  = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
    assign dvd    = DVD_W'(mag_n) << FRAC_BITS;
    assign dvd_hi = dvd >> QBITS;
    assign ovf    = dvd_hi >= DVD_W'(mag_d);

    // restoring step
    assign trial = {rem_reg[REM_W-2:0], lo_reg[QBITS-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= ovf ? '0 : QCNT_W'(QBITS);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= REM_W'(dvd_hi);
            lo_reg  <= dvd[QBITS-1:0];
            quo_reg <= '0;
            d_reg   <= mag_d;
            neg_reg <= num[ACC_W-1] ^ den[ACC_W-1];
            ovf_reg <= ovf;
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg <= ge ? trial - {1'b0, d_reg} : trial;
            lo_reg  <= {lo_reg[QBITS-2:0], 1'b0};
            quo_reg <= {quo_reg[QBITS-2:0], ge};
        end
    end

    // sign and saturation
    assign q32  = {1'b0, quo_reg};
    assign done = busy_reg && (cnt_reg == '0);
    always_comb begin
        if (ovf_reg)
            quot = neg_reg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            quot = neg_reg ? DATA_W'(-q32) : q32;
    end

endmodule

// ===== rtl/kf2_datapath.sv =====
// ---------------------------------------------------------------------------
// kf2_datapath
// Filter state, shared multiplier with accumulator, gain divider and the
// output register, all stepped by commands from the controller.
// ---------------------------------------------------------------------------
module kf2_datapath #(
    parameter int FRAC_BITS = kf2_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [kf2_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kf2_pkg::DATA_W-1:0]          cfg_data,
    input  logic [2*kf2_pkg::DATA_W-1:0]        in_data,
    input  kf2_pkg::ctrl_t                      ctrl,
    output kf2_pkg::stat_t                      stat,
    output logic [2*kf2_pkg::DATA_W-1:0]        out_data,
    output logic                                out_flag
);
    import kf2_pkg::*;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    function automatic logic signed [ACC_W-1:0] sx(logic [DATA_W-1:0] v);
        return $signed({{(ACC_W-DATA_W){v[DATA_W-1]}}, v});
    endfunction

    function automatic logic signed [ACC_W-1:0] zx(logic [DATA_W-1:0] v);
        return $signed({{(ACC_W-DATA_W){1'b0}}, v});
    endfunction

    function automatic logic signed [OPD_W-1:0] sx33(logic [DATA_W-1:0] v);
        return $signed({v[DATA_W-1], v});
    endfunction

    logic [DATA_W-1:0]        q_reg, r1_reg, r2_reg;
    logic [DATA_W-1:0]        x_reg [2];
    logic [DATA_W-1:0]        cov_reg [4];
    logic [DATA_W-1:0]        z_reg [2];
    logic [DATA_W-1:0]        p_reg [4];
    logic [DATA_W-1:0]        s0_reg, s3_reg;
    logic signed [OPD_W-1:0]  y_reg [2];
    logic [DATA_W-1:0]        k_reg [4];
    logic signed [ACC_W-1:0]  prod_reg, acc_reg, det_reg, m_reg;
    logic [2*DATA_W-1:0]      out_data_reg;
    logic                     out_flag_reg;

    logic [DATA_W-1:0]        p0_next, p3_next;
    logic signed [OPD_W-1:0]  a_op, b_sel, b_op;
    logic signed [OPD_W-1:0]  ik [4];
    logic signed [ACC_W-1:0]  fp, base_val, acc_src, acc_next;
    logic                     div_done;
    logic [DATA_W-1:0]        div_quot;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg  <= ONE;
            r1_reg <= ONE;
            r2_reg <= ONE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_Q:   q_reg  <= cfg_data;
                REG_R1:  r1_reg <= cfg_data;
                REG_R2:  r2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // predicted diagonal
    assign p0_next = sat32(sx(cov_reg[0]) + zx(q_reg));
    assign p3_next = sat32(sx(cov_reg[3]) + zx(q_reg));

    // I - K
    assign ik[0] = $signed(OPD_W'(ONE)) - sx33(k_reg[0]);
    assign ik[1] = -sx33(k_reg[1]);
    assign ik[2] = -sx33(k_reg[2]);
    assign ik[3] = $signed(OPD_W'(ONE)) - sx33(k_reg[3]);

    // operand selection
    always_comb begin
        unique case (ctrl.op.a_sel)
            A_S0:    a_op = sx33(s0_reg);
            A_P0:    a_op = sx33(p_reg[0]);
            A_P1:    a_op = sx33(p_reg[1]);
            A_P2:    a_op = sx33(p_reg[2]);
            A_P3:    a_op = sx33(p_reg[3]);
            A_K0:    a_op = sx33(k_reg[0]);
            A_K1:    a_op = sx33(k_reg[1]);
            A_K2:    a_op = sx33(k_reg[2]);
            A_K3:    a_op = sx33(k_reg[3]);
            A_IK0:   a_op = ik[0];
            A_IK1:   a_op = ik[1];
            A_IK2:   a_op = ik[2];
            A_IK3:   a_op = ik[3];
            default: a_op = '0;
        endcase
        unique case (ctrl.op.b_sel)
            B_S3:    b_sel = sx33(s3_reg);
            B_P0:    b_sel = sx33(p_reg[0]);
            B_P1:    b_sel = sx33(p_reg[1]);
            B_P2:    b_sel = sx33(p_reg[2]);
            B_P3:    b_sel = sx33(p_reg[3]);
            B_S0:    b_sel = sx33(s0_reg);
            B_Y0:    b_sel = y_reg[0];
            B_Y1:    b_sel = y_reg[1];
            default: b_sel = '0;
        endcase
        b_op = ctrl.op.neg_b ? -b_sel : b_sel;
    end

    // rescaled product, floor rounding, and accumulate
    assign fp = prod_reg >>> FRAC_BITS;
    always_comb begin
        unique case (ctrl.op.base)
            BASE_X0: base_val = sx(x_reg[0]);
            BASE_X1: base_val = sx(x_reg[1]);
            default: base_val = '0;
        endcase
        acc_src  = ctrl.op.first ? base_val : acc_reg;
        acc_next = ctrl.op.sub ? acc_src - fp : acc_src + fp;
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg[0]   <= '0;
            x_reg[1]   <= '0;
            cov_reg[0] <= ONE;
            cov_reg[1] <= '0;
            cov_reg[2] <= '0;
            cov_reg[3] <= ONE;
        end else if (ctrl.keep_pred) begin
            for (int i = 0; i < 4; i++) cov_reg[i] <= p_reg[i];
        end else if (ctrl.acc_en) begin
            unique case (ctrl.op.dst)
                DST_X0:  x_reg[0]   <= sat32(acc_next);
                DST_X1:  x_reg[1]   <= sat32(acc_next);
                DST_C0:  cov_reg[0] <= sat32(acc_next);
                DST_C1:  cov_reg[1] <= sat32(acc_next);
                DST_C2:  cov_reg[2] <= sat32(acc_next);
                DST_C3:  cov_reg[3] <= sat32(acc_next);
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            z_reg[0] <= in_data[DATA_W-1:0];
            z_reg[1] <= in_data[2*DATA_W-1:DATA_W];
        end
        if (ctrl.pred) begin
            p_reg[0] <= p0_next;
            p_reg[1] <= cov_reg[1];
            p_reg[2] <= cov_reg[2];
            p_reg[3] <= p3_next;
            s0_reg   <= sat32(sx(p0_next) + zx(r1_reg));
            s3_reg   <= sat32(sx(p3_next) + zx(r2_reg));
            y_reg[0] <= sx33(z_reg[0]) - sx33(x_reg[0]);
            y_reg[1] <= sx33(z_reg[1]) - sx33(x_reg[1]);
        end
        if (ctrl.mul_en) begin
            prod_reg <= a_op * b_op;
        end
        if (ctrl.acc_en) begin
            acc_reg <= acc_next;
            if (ctrl.op.dst == DST_DET) det_reg <= acc_next;
            if (ctrl.op.dst == DST_M)   m_reg   <= acc_next;
        end
        if (div_done) begin
            k_reg[ctrl.op.kidx] <= div_quot;
        end
        if (ctrl.out_load) begin
            out_data_reg <= {x_reg[1], x_reg[0]};
            out_flag_reg <= ctrl.singular;
        end
    end

    kf2_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .num     (m_reg),
        .den     (det_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign stat.det_zero = (det_reg == '0);
    assign stat.div_done = div_done;
    assign out_data      = out_data_reg;
    assign out_flag      = out_flag_reg;

endmodule

// ===== rtl/kf2_ctrl.sv =====
// ---------------------------------------------------------------------------
// kf2_ctrl
// Sequencer: walks the product table, starts the gain divides, handles the
// singular case and owns both handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kf2_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  kf2_pkg::stat_t stat,
    output kf2_pkg::ctrl_t ctrl
);
    import kf2_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PRED   = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_ACC    = 4'd3;
    localparam logic [3:0] ST_CHK    = 4'd4;
    localparam logic [3:0] ST_DSTART = 4'd5;
    localparam logic [3:0] ST_DWAIT  = 4'd6;
    localparam logic [3:0] ST_SING   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              sing_reg, sing_next;
    logic              mval_reg, mval_next;
    logic              out_free;
    op_t               op;

    assign op       = step_op(step_reg);
    assign out_free = !mval_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        sing_next  = sing_reg;
        ctrl       = '0;
        ctrl.op    = op;
        ctrl.singular = sing_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load_in = 1'b1;
                    state_next   = ST_PRED;
                end
            end
            ST_PRED: begin
                ctrl.pred  = 1'b1;
                step_next  = '0;
                sing_next  = 1'b0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                ctrl.acc_en = 1'b1;
                priority if (step_reg == STEP_DET) begin
                    state_next = ST_CHK;
                end else if (op.div) begin
                    state_next = ST_DSTART;
                end else if (step_reg == STEP_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_CHK: begin
                if (stat.det_zero) begin
                    state_next = ST_SING;
                end else begin
                    step_next  = STEP_M0;
                    state_next = ST_MUL;
                end
            end
            ST_DSTART: begin
                ctrl.div_start = 1'b1;
                state_next     = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (stat.div_done) begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_SING: begin
                ctrl.keep_pred = 1'b1;
                sing_next      = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid
    always_comb begin
        mval_next = mval_reg;
        if (ctrl.out_load)
            mval_next = 1'b1;
        else if (m_tready)
            mval_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sing_reg  <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sing_reg  <= sing_next;
            mval_reg  <= mval_next;
        end
    end

    `KF_NEVER(a_out_overwrite, ctrl.out_load && mval_reg && !m_tready, "result beat overwritten while stalled")
    `KF_ASSERT(a_accept_pred, (s_tvalid && s_tready) |=> (state_reg == ST_PRED), "accepted beat not followed by predict")
    `KF_NEVER(a_step_range, step_reg > STEP_LAST, "step counter past end of sequence")
    `KF_ASSERT(a_div_done_wait, stat.div_done |-> (state_reg == ST_DWAIT), "divider finished outside wait state")

endmodule

// ===== rtl/kalman_filter_2state.sv =====
// ---------------------------------------------------------------------------
// kalman_filter_2state
// Two-state Kalman filter, identity models, signed fixed point.
// ---------------------------------------------------------------------------
// Input beats on s_* carry two measurements; each produces one result beat
// on m_* with the two updated estimates and a singular flag in m_tuser.
// Noise variances are written through cfg_* (index 0 process, 1 and 2
// measurement); the user must write them only while the block is idle,
// which the block itself does not enforce; cfg_ready is always high.
// One item is processed at a time, mostly in the shared multiplier
// (22 products) and the serial gain divider (4 divides).
// A singular innovation (zero determinant) skips the gain and update steps.
// Reset (aresetn low, synchronous) clears the estimate, sets the
// covariance to identity and all variances to 1.0.
// A finished result waits in the output register while m_tready is low;
// the next input is accepted meanwhile and held before its own result
// until that register frees.
// ---------------------------------------------------------------------------
module kalman_filter_2state #(
    parameter int FRAC_BITS = kf2_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*kf2_pkg::DATA_W-1:0]        s_tdata,   // meas_first, meas_second
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2*kf2_pkg::DATA_W-1:0]        m_tdata,   // est_first, est_second
    output logic                                m_tuser,   // singular
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kf2_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kf2_pkg::DATA_W-1:0]          cfg_data
);
    import kf2_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    kf2_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    kf2_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_data  (m_tdata),
        .out_flag  (m_tuser)
    );

endmodule

// ===== dv/kalman_filter_2state_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kalman_filter_2state_tb
// Self-checking bench for the two-state fixed-point Kalman filter.
// ---------------------------------------------------------------------------
// Measurement beats come from a queue that the stimulus block fills. A
// bit-exact predictor tracks estimate and covariance and queues the result
// expected for each accepted beat. The monitor compares every result beat
// field by field. Variance registers are rewritten between phases, and only
// while the filter is idle.
// ---------------------------------------------------------------------------
module kalman_filter_2state_tb;
    import kf2_pkg::*;

    localparam int FB = 16;

    typedef struct packed {
        logic [31:0] meas_second;
        logic [31:0] meas_first;
    } meas_t;

    typedef struct packed {
        logic [31:0] est_second;
        logic [31:0] est_first;
        logic        singular;
    } est_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    kalman_filter_2state dut (.*);

    // filter state as tracked by the predictor
    logic [31:0]        var_q, var_r1, var_r2;
    logic signed [31:0] est_x [2];
    logic signed [31:0] cov_p [4];

    meas_t meas_queue[$];
    est_t  est_queue[$];
    int    err_count;
    bit    gen_done;
    bit    drv_hold;

    // --- fixed-point helpers ---
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // rescaled product, rounded toward minus infinity
    function automatic longint fx_mul(longint a, longint b);
        logic signed [127:0] w;
        w = 128'(a) * 128'(b);
        return longint'(w >>> FB);
    endfunction

    function automatic longint gain_div(longint num, longint den);
        bit                neg;
        logic       [63:0] n, d, qt;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        if (n > (64'hFFFF_FFFF_FFFF_FFFF >> FB)) qt = 64'hFFFF_FFFF_FFFF_FFFF;
        else qt = (n << FB) / d;
        if (neg) begin
            if (qt >= 64'h8000_0000) return -64'sd2147483648;
            return -longint'(qt);
        end
        if (qt > 64'h7FFF_FFFF) return 64'sd2147483647;
        return longint'(qt);
    endfunction

    // one filter step: updates the tracked state, returns the result beat
    function automatic est_t kalman_step(meas_t z);
        longint p[4], s[4], m[4], y[2], ik[4], k[4], det;
        est_t   r;
        p[0] = clamp32(longint'(cov_p[0]) + longint'({32'd0, var_q}));
        p[1] = cov_p[1];
        p[2] = cov_p[2];
        p[3] = clamp32(longint'(cov_p[3]) + longint'({32'd0, var_q}));
        s[0] = clamp32(p[0] + longint'({32'd0, var_r1}));
        s[1] = p[1];
        s[2] = p[2];
        s[3] = clamp32(p[3] + longint'({32'd0, var_r2}));
        det  = fx_mul(s[0], s[3]) - fx_mul(s[1], s[2]);
        r.singular = (det == 0);
        if (det == 0) begin
            for (int i = 0; i < 4; i++) cov_p[i] = 32'(p[i]);
        end else begin
            m[0] = fx_mul(p[0], s[3]) + fx_mul(p[1], -s[2]);
            m[1] = fx_mul(p[0], -s[1]) + fx_mul(p[1], s[0]);
            m[2] = fx_mul(p[2], s[3]) + fx_mul(p[3], -s[2]);
            m[3] = fx_mul(p[2], -s[1]) + fx_mul(p[3], s[0]);
            for (int i = 0; i < 4; i++) k[i] = gain_div(m[i], det);
            y[0] = longint'($signed(z.meas_first)) - est_x[0];
            y[1] = longint'($signed(z.meas_second)) - est_x[1];
            for (int i = 0; i < 2; i++)
                est_x[i] = 32'(clamp32(longint'(est_x[i]) + fx_mul(k[2*i], y[0])
                                       + fx_mul(k[2*i+1], y[1])));
            for (int i = 0; i < 4; i++) ik[i] = -k[i];
            ik[0] += 64'sd1 << FB;
            ik[3] += 64'sd1 << FB;
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    cov_p[2*i+j] = 32'(clamp32(fx_mul(ik[2*i], p[j])
                                               + fx_mul(ik[2*i+1], p[2+j])));
        end
        r.est_first  = est_x[0];
        r.est_second = est_x[1];
        return r;
    endfunction

    // --- clock and limit ---
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // --- driver: bursts and gaps ---
    int burst_left, gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            // current beat is gone or none shown
            if (s_tvalid) begin
                est_queue.push_back(kalman_step(meas_t'(s_tdata)));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (meas_queue.size() > 0 && !drv_hold) begin
                s_tdata  <= meas_queue.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // --- monitor with its own stall pattern ---
    int stall_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                est_t act, exp_r;
                act = {m_tdata[63:32], m_tdata[31:0], m_tuser};
                if (est_queue.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, act);
                    err_count++;
                end else begin
                    exp_r = est_queue.pop_front();
                    if (act.est_first !== exp_r.est_first) begin
                        $display("%0t: est_first exp %h got %h", $time,
                                 exp_r.est_first, act.est_first);
                        err_count++;
                    end
                    if (act.est_second !== exp_r.est_second) begin
                        $display("%0t: est_second exp %h got %h", $time,
                                 exp_r.est_second, act.est_second);
                        err_count++;
                    end
                    if (act.singular !== exp_r.singular) begin
                        $display("%0t: singular exp %b got %b", $time,
                                 exp_r.singular, act.singular);
                        err_count++;
                    end
                end
            end
            // long ready stretches mixed with stretches of random stalls
            stall_phase <= (stall_phase + 1) % 1024;
            if (stall_phase < 512) m_tready <= 1'b1;
            else if (stall_phase < 700) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 7) == 0);
        end
    end

    // --- stimulus ---
    task automatic wait_idle();
        while (meas_queue.size() > 0 || s_tvalid || est_queue.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // one config beat, then cfg_valid low before the next write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_Q:   var_q  = val;
            REG_R1:  var_r1 = val;
            REG_R2:  var_r2 = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_var();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 4) << 16;
            1: return $urandom_range(0, 65535);
            2: return 32'hFFFF_FFFF;
            3: return $urandom();
            default: return $urandom_range(1, 400000);
        endcase
    endfunction

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    initial begin
        logic [31:0] edge_vals[6];
        err_count = 0;
        gen_done  = 0;
        drv_hold  = 0;
        aresetn   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        var_q  = 32'h0001_0000;
        var_r1 = 32'h0001_0000;
        var_r2 = 32'h0001_0000;
        est_x  = '{0, 0};
        cov_p  = '{32'h0001_0000, 0, 0, 32'h0001_0000};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes at reset variances
        edge_vals = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
        foreach (edge_vals[i])
            meas_queue.push_back({edge_vals[(i + 2) % 6], edge_vals[i]});
        wait_idle();

        // zero variances with zeroed covariance path gives a singular innovation
        write_reg(REG_Q, 32'h0);
        write_reg(REG_R1, 32'h0);
        write_reg(REG_R2, 32'h0);
        // unused index is ignored
        write_reg(2'd3, 32'h1234_5678);
        for (int i = 0; i < 6; i++) meas_queue.push_back({rand_meas(), rand_meas()});
        wait_idle();

        // huge variances saturate the diagonal
        write_reg(REG_Q, 32'hFFFF_FFFF);
        write_reg(REG_R1, 32'hFFFF_FFFF);
        write_reg(REG_R2, 32'h0);
        for (int i = 0; i < 6; i++) meas_queue.push_back({rand_meas(), rand_meas()});
        wait_idle();

        write_reg(REG_Q, 32'h0);
        write_reg(REG_R1, 32'h0000_0001);
        write_reg(REG_R2, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++) meas_queue.push_back({rand_meas(), rand_meas()});
        wait_idle();

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_Q, rand_var());
            write_reg(REG_R1, rand_var());
            write_reg(REG_R2, rand_var());
            for (int i = 0; i < 100; i++) begin
                meas_queue.push_back({rand_meas(), rand_meas()});
                if (i == 50 && ph == 3) begin
                    // let part of the queue go out, then hold the sender until drained
                    while (meas_queue.size() > 25) @(posedge aclk);
                    drv_hold = 1;
                    while (s_tvalid || est_queue.size() > 0) @(posedge aclk);
                    repeat (20) @(posedge aclk);
                    drv_hold = 0;
                end
            end
            wait_idle();
        end

        repeat (300) @(posedge aclk);
        if (err_count == 0 && est_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
